### sv/mpam_pkg.sv
// shared types and constants for the max pooling argmax location unit
package mpam_pkg;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // field widths
  localparam int INDEX_W    = 12;
  localparam int VALUE_W    = 16;
  localparam int QUERY_W    = 6;
  localparam int LOC_W      = 16;
  localparam int DIM_W      = 7;
  localparam int WIN_W      = 5;
  localparam int PAD_W      = 4;
  localparam int CFG_DATA_W = 7;
  localparam int REG_IDX_W  = 3;
  // signed window origin: covers 63*31 down to -15
  localparam int OFS_W      = 13;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLANE_HEIGHT    = 3'd0,
    REG_PLANE_WIDTH     = 3'd1,
    REG_WINDOW_HEIGHT   = 3'd2,
    REG_WINDOW_WIDTH    = 3'd3,
    REG_STEP_ROWS       = 3'd4,
    REG_STEP_COLS       = 3'd5,
    REG_PAD_ROWS_BEFORE = 3'd6,
    REG_PAD_COLS_BEFORE = 3'd7
  } reg_idx_t;

  // register reset values
  localparam logic [DIM_W-1:0] RST_PLANE_HEIGHT    = 7'd1;
  localparam logic [DIM_W-1:0] RST_PLANE_WIDTH     = 7'd1;
  localparam logic [WIN_W-1:0] RST_WINDOW_HEIGHT   = 5'd2;
  localparam logic [WIN_W-1:0] RST_WINDOW_WIDTH    = 5'd2;
  localparam logic [WIN_W-1:0] RST_STEP_ROWS       = 5'd2;
  localparam logic [WIN_W-1:0] RST_STEP_COLS       = 5'd2;
  localparam logic [PAD_W-1:0] RST_PAD_ROWS_BEFORE = 4'd0;
  localparam logic [PAD_W-1:0] RST_PAD_COLS_BEFORE = 4'd0;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;
    logic capture;
    logic origin;
    logic bounds;
    logic base;
    logic scan;
    logic result;
  } mpam_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic last;
  } mpam_sts_t;

endpackage

### sv/mpam_ram.sv
// generic single write port ram with registered read
module mpam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/mpam_ctrl.sv
// controller state machine: sequences load, window setup, scan and result
module mpam_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mpam_pkg::mpam_sts_t sts,
  output mpam_pkg::mpam_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    ORIGIN,
    BOUNDS,
    BASE,
    SCAN,
    DRAIN,
    RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      IDLE: begin
        if (in_valid) begin
          if (in_req_type == mpam_pkg::REQ_QUERY) begin
            cmd.capture = 1'b1;
            state_nxt   = ORIGIN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ORIGIN: begin
        cmd.origin = 1'b1;
        state_nxt  = BOUNDS;
      end
      BOUNDS: begin
        cmd.bounds = 1'b1;
        state_nxt  = BASE;
      end
      BASE: begin
        cmd.base  = 1'b1;
        state_nxt = sts.empty ? RESULT : SCAN;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_nxt = DRAIN;
        end
      end
      DRAIN: begin
        state_nxt = RESULT;
      end
      RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/mpam_dp.sv
// datapath: config registers, window bounds, scan address, running max, result
module mpam_dp #(
  parameter int MAX_PLANE_HEIGHT = 64,
  parameter int MAX_PLANE_WIDTH  = 64,
  parameter int MAX_WINDOW       = 16,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mpam_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mpam_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [mpam_pkg::INDEX_W-1:0]          in_sample_index,
  input  logic signed [mpam_pkg::VALUE_W-1:0]   in_sample_value,
  input  logic [mpam_pkg::QUERY_W-1:0]          in_query_row,
  input  logic [mpam_pkg::QUERY_W-1:0]          in_query_col,
  input  mpam_pkg::mpam_cmd_t                   cmd,
  output mpam_pkg::mpam_sts_t                   sts,
  output logic [mpam_pkg::LOC_W-1:0]            out_max_location,
  output logic                                  out_window_empty
);

  localparam int DEPTH  = MAX_PLANE_HEIGHT * MAX_PLANE_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW     = mpam_pkg::OFS_W;
  localparam int DW     = mpam_pkg::DIM_W;
  localparam int WW     = mpam_pkg::WIN_W;
  localparam int PW     = mpam_pkg::PAD_W;
  localparam int QW     = mpam_pkg::QUERY_W;
  localparam int LCW    = mpam_pkg::LOC_W;
  localparam int BASE_W = OW - 1 + DW;
  localparam int LW     = (AW > BASE_W) ? AW : BASE_W;

  // config registers
  logic [DW-1:0] ph_r, pw_r;
  logic [WW-1:0] wh_r, ww_r, sr_r, sc_r;
  logic [PW-1:0] pr_r, pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= mpam_pkg::RST_PLANE_HEIGHT;
      pw_r <= mpam_pkg::RST_PLANE_WIDTH;
      wh_r <= mpam_pkg::RST_WINDOW_HEIGHT;
      ww_r <= mpam_pkg::RST_WINDOW_WIDTH;
      sr_r <= mpam_pkg::RST_STEP_ROWS;
      sc_r <= mpam_pkg::RST_STEP_COLS;
      pr_r <= mpam_pkg::RST_PAD_ROWS_BEFORE;
      pc_r <= mpam_pkg::RST_PAD_COLS_BEFORE;
    end else if (cfg_we) begin
      unique case (mpam_pkg::reg_idx_t'(cfg_index))
        mpam_pkg::REG_PLANE_HEIGHT:    ph_r <= cfg_data[DW-1:0];
        mpam_pkg::REG_PLANE_WIDTH:     pw_r <= cfg_data[DW-1:0];
        mpam_pkg::REG_WINDOW_HEIGHT:   wh_r <= cfg_data[WW-1:0];
        mpam_pkg::REG_WINDOW_WIDTH:    ww_r <= cfg_data[WW-1:0];
        mpam_pkg::REG_STEP_ROWS:       sr_r <= cfg_data[WW-1:0];
        mpam_pkg::REG_STEP_COLS:       sc_r <= cfg_data[WW-1:0];
        mpam_pkg::REG_PAD_ROWS_BEFORE: pr_r <= cfg_data[PW-1:0];
        mpam_pkg::REG_PAD_COLS_BEFORE: pc_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // saturated dimensions
  logic [DW-1:0] ph_sat, pw_sat;
  logic [WW-1:0] wh_sat, ww_sat;

  assign ph_sat = (32'(ph_r) > MAX_PLANE_HEIGHT) ? DW'(MAX_PLANE_HEIGHT) : ph_r;
  assign pw_sat = (32'(pw_r) > MAX_PLANE_WIDTH)  ? DW'(MAX_PLANE_WIDTH)  : pw_r;
  assign wh_sat = (32'(wh_r) > MAX_WINDOW) ? WW'(MAX_WINDOW) : wh_r;
  assign ww_sat = (32'(ww_r) > MAX_WINDOW) ? WW'(MAX_WINDOW) : ww_r;

  // query capture and window origin
  logic [QW-1:0]      qr_r, qc_r;
  logic [QW+WW-1:0]   row_prod, col_prod;
  logic signed [OW-1:0] oy_r, ox_r;

  assign row_prod = qr_r * sr_r;
  assign col_prod = qc_r * sc_r;

  // clipped bounds
  logic signed [OW-1:0] y0_nxt, x0_nxt, ylim, xlim, yend_nxt, xend_nxt;
  logic signed [OW-1:0] ph_s, pw_s;
  logic signed [OW-1:0] y0_r, x0_r, yend_r, xend_r;
  logic                 empty_r;

  assign ph_s     = $signed(OW'(ph_sat));
  assign pw_s     = $signed(OW'(pw_sat));
  assign y0_nxt   = oy_r[OW-1] ? '0 : oy_r;
  assign x0_nxt   = ox_r[OW-1] ? '0 : ox_r;
  assign ylim     = oy_r + $signed(OW'(wh_sat));
  assign xlim     = ox_r + $signed(OW'(ww_sat));
  assign yend_nxt = (ylim < ph_s) ? ylim : ph_s;
  assign xend_nxt = (xlim < pw_s) ? xlim : pw_s;

  // scan position
  logic [BASE_W-1:0]    base_prod;
  logic [LW-1:0]        rowbase_r, scan_addr;
  logic signed [OW-1:0] y_r, x_r, y_inc, x_inc;
  logic                 x_last, y_last;

  assign base_prod = y0_r[OW-2:0] * pw_sat;
  assign scan_addr = rowbase_r + LW'(x_r[OW-2:0]);
  assign y_inc     = y_r + OW'(1);
  assign x_inc     = x_r + OW'(1);
  assign x_last    = (x_inc == xend_r);
  assign y_last    = (y_inc == yend_r);

  // running maximum
  logic                          rd_pend_r;
  logic [LCW-1:0]                rd_loc_r, best_loc_r, start_loc;
  logic signed [SAMPLE_BITS-1:0] best_r;
  logic                          found_r;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic                          take;

  assign take      = rd_pend_r && (!found_r || ($signed(rdata) > best_r));
  assign start_loc = rowbase_r[LCW-1:0] + LCW'(x0_r[OW-2:0]);

  // result register
  logic [LCW-1:0] out_loc_r;
  logic           out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qr_r <= in_query_row;
      qc_r <= in_query_col;
    end
    if (cmd.origin) begin
      oy_r <= OW'(row_prod) - OW'(pr_r);
      ox_r <= OW'(col_prod) - OW'(pc_r);
    end
    if (cmd.bounds) begin
      y0_r    <= y0_nxt;
      x0_r    <= x0_nxt;
      yend_r  <= yend_nxt;
      xend_r  <= xend_nxt;
      empty_r <= (yend_nxt <= y0_nxt) || (xend_nxt <= x0_nxt);
    end
    if (cmd.base) begin
      rowbase_r <= LW'(base_prod);
      y_r       <= y0_r;
      x_r       <= x0_r;
    end else if (cmd.scan) begin
      if (x_last) begin
        x_r       <= x0_r;
        y_r       <= y_inc;
        rowbase_r <= rowbase_r + LW'(pw_sat);
      end else begin
        x_r <= x_inc;
      end
    end
    if (cmd.scan) begin
      rd_loc_r <= scan_addr[LCW-1:0];
    end
    if (cmd.base) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r    <= 1'b1;
      best_r     <= $signed(rdata);
      best_loc_r <= rd_loc_r;
    end
    if (cmd.result) begin
      out_loc_r   <= found_r ? best_loc_r : start_loc;
      out_empty_r <= !found_r;
    end
  end

  mpam_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_wr && (32'(in_sample_index) < DEPTH)),
    .waddr (AW'(in_sample_index)),
    .wdata (SAMPLE_BITS'(in_sample_value)),
    .raddr (scan_addr[AW-1:0]),
    .rdata (rdata)
  );

  assign sts.empty        = empty_r;
  assign sts.last         = x_last && y_last;
  assign out_max_location = out_loc_r;
  assign out_window_empty = out_empty_r;

endmodule

### sv/maxpool2d_argmax_location_unit.sv
// top level of the max pooling unit that reports the location of the window maximum
//
// The unit keeps one plane of signed samples in an on-chip store and answers
// pooling queries against it. A load beat (req_type 0) writes one sample at a
// raster index; loads at or beyond the store depth are dropped. A query beat
// (req_type 1) names an output row and column: the strided window is placed,
// shifted up and left by the leading padding, clipped to the plane and scanned
// in raster order, and the result beat carries row*plane_width+col of the first
// maximum (strictly greater wins, so the earliest tie is kept). A window that
// clips to nothing returns its clipped start location with window_empty set. The
// unit takes no new request until a query's result beat is issued; the scan
// reads the store through its one read port, one sample per cycle. Loads take a
// beat every cycle while the unit is idle. The store contents are undefined
// after reset and need no clearing pass: only loaded entries may be covered by
// a query. Configuration must be written only while the unit is idle; the unit
// itself does not enforce this.
module maxpool2d_argmax_location_unit #(
  parameter int MAX_PLANE_HEIGHT = 64,
  parameter int MAX_PLANE_WIDTH  = 64,
  parameter int MAX_WINDOW       = 16,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mpam_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mpam_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [mpam_pkg::INDEX_W-1:0]        in_sample_index,
  input  logic signed [mpam_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [mpam_pkg::QUERY_W-1:0]        in_query_row,
  input  logic [mpam_pkg::QUERY_W-1:0]        in_query_col,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mpam_pkg::LOC_W-1:0]          out_max_location,
  output logic                                out_window_empty
);

  mpam_pkg::mpam_cmd_t cmd;
  mpam_pkg::mpam_sts_t sts;

  // sequencer: one query at a time, loads pass straight through in idle
  mpam_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // store, bounds math, scan counters and the running max
  mpam_dp #(
    .MAX_PLANE_HEIGHT (MAX_PLANE_HEIGHT),
    .MAX_PLANE_WIDTH  (MAX_PLANE_WIDTH),
    .MAX_WINDOW       (MAX_WINDOW),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample_index  (in_sample_index),
    .in_sample_value  (in_sample_value),
    .in_query_row     (in_query_row),
    .in_query_col     (in_query_col),
    .cmd              (cmd),
    .sts              (sts),
    .out_max_location (out_max_location),
    .out_window_empty (out_window_empty)
  );

endmodule

### sv/mpam_checker.sv
// port level checks for the max pooling argmax location unit, with its bind
module mpam_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_req_type,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mpam_pkg::LOC_W-1:0]     out_max_location,
  input logic                           out_window_empty
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_location)
      && $stable(out_window_empty))
    else $error("result beat changed while stalled");

  // an accepted query occupies the unit in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == mpam_pkg::REQ_QUERY) |=> in_stall)
    else $error("request taken right after a query");

  // a load never produces a result beat
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == mpam_pkg::REQ_LOAD) && !out_valid
      |=> !out_valid)
    else $error("result beat after a load");

  // a new result appears only at the end of query work
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without query work");

endmodule

bind maxpool2d_argmax_location_unit mpam_checker u_mpam_checker (.*);

### test/argmax_checker.sv
// checker for the pooling unit: predicts each window maximum location and compares result beats
module argmax_checker
  import mpam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [INDEX_W-1:0]   in_sample_index,
  input  logic signed [VALUE_W-1:0] in_sample_value,
  input  logic [QUERY_W-1:0]   in_query_row,
  input  logic [QUERY_W-1:0]   in_query_col,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [LOC_W-1:0]     out_max_location,
  input  logic                 out_window_empty,
  output int                   fail_total,
  output int                   results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_ROWS_MAX = 64;
  localparam int PLANE_COLS_MAX = 64;
  localparam int WINDOW_MAX     = 16;
  localparam int PLANE_DEPTH    = PLANE_ROWS_MAX * PLANE_COLS_MAX;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic             empty;
  } pool_result_t;

  // mirrored geometry registers
  logic [DIM_W-1:0] plane_rows, plane_cols;
  logic [WIN_W-1:0] win_rows, win_cols, stride_rows, stride_cols;
  logic [PAD_W-1:0] pad_rows, pad_cols;

  logic signed [VALUE_W-1:0] plane_mem [0:PLANE_DEPTH-1];
  pool_result_t awaited_argmax [$];
  int mismatches;

  initial begin
    for (int i = 0; i < PLANE_DEPTH; i++) plane_mem[i] = '0;
    mismatches = 0;
    fail_total = 0;
    results_waiting = 0;
  end

  function automatic int clamp_dim(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  // clipped window scan, earliest strict maximum wins
  function automatic pool_result_t window_argmax(input logic [QUERY_W-1:0] qr,
                                                 input logic [QUERY_W-1:0] qc);
    int ph, pw, wh, ww, oy, ox, ys, xs, ye, xe, addr, loc;
    logic signed [VALUE_W-1:0] best, v;
    bit found;
    pool_result_t r;
    ph = clamp_dim(int'(plane_rows), PLANE_ROWS_MAX);
    pw = clamp_dim(int'(plane_cols), PLANE_COLS_MAX);
    wh = clamp_dim(int'(win_rows), WINDOW_MAX);
    ww = clamp_dim(int'(win_cols), WINDOW_MAX);
    oy = int'(qr) * int'(stride_rows) - int'(pad_rows);
    ox = int'(qc) * int'(stride_cols) - int'(pad_cols);
    ys = (oy < 0) ? -oy : 0;
    xs = (ox < 0) ? -ox : 0;
    ye = (wh < ph - oy) ? wh : ph - oy;
    xe = (ww < pw - ox) ? ww : pw - ox;
    loc = (oy + ys) * pw + (ox + xs);
    found = 1'b0;
    best = '0;
    for (int fy = ys; fy < ye; fy++) begin
      for (int fx = xs; fx < xe; fx++) begin
        addr = (oy + fy) * pw + (ox + fx);
        v = (addr < PLANE_DEPTH) ? plane_mem[addr] : '0;
        if (!found || v > best) begin
          found = 1'b1;
          best = v;
          loc = addr;
        end
      end
    end
    r.location = loc[LOC_W-1:0];
    r.empty = !found;
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t exp_r;
    if (!rst_n) begin
      plane_rows  = RST_PLANE_HEIGHT;
      plane_cols  = RST_PLANE_WIDTH;
      win_rows    = RST_WINDOW_HEIGHT;
      win_cols    = RST_WINDOW_WIDTH;
      stride_rows = RST_STEP_ROWS;
      stride_cols = RST_STEP_COLS;
      pad_rows    = RST_PAD_ROWS_BEFORE;
      pad_cols    = RST_PAD_COLS_BEFORE;
      awaited_argmax.delete();
    end else begin
      // result beat first, so a beat is never matched against a query of the same edge
      if (out_valid && !out_stall) begin
        if (awaited_argmax.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual location %0d empty %0b",
                   $time, out_max_location, out_window_empty);
          mismatches++;
        end else begin
          exp_r = awaited_argmax.pop_front();
          if (out_max_location !== exp_r.location) begin
            $display("%0t max_location mismatch: expected %0d actual %0d",
                     $time, exp_r.location, out_max_location);
            mismatches++;
          end
          if (out_window_empty !== exp_r.empty) begin
            $display("%0t window_empty mismatch: expected %0b actual %0b",
                     $time, exp_r.empty, out_window_empty);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PLANE_HEIGHT:    plane_rows  = cfg_data[DIM_W-1:0];
          REG_PLANE_WIDTH:     plane_cols  = cfg_data[DIM_W-1:0];
          REG_WINDOW_HEIGHT:   win_rows    = cfg_data[WIN_W-1:0];
          REG_WINDOW_WIDTH:    win_cols    = cfg_data[WIN_W-1:0];
          REG_STEP_ROWS:       stride_rows = cfg_data[WIN_W-1:0];
          REG_STEP_COLS:       stride_cols = cfg_data[WIN_W-1:0];
          REG_PAD_ROWS_BEFORE: pad_rows    = cfg_data[PAD_W-1:0];
          REG_PAD_COLS_BEFORE: pad_cols    = cfg_data[PAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_LOAD) begin
          if (int'(in_sample_index) < PLANE_DEPTH) plane_mem[in_sample_index] = in_sample_value;
        end else begin
          awaited_argmax.push_back(window_argmax(in_query_row, in_query_col));
        end
      end
    end
    fail_total <= mismatches;
    results_waiting <= awaited_argmax.size();
  end

endmodule

### test/tb_top.sv
// testbench top for the pooling argmax location unit: stimulus, stalls and verdict
module tb_top;
  import mpam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_MAX     = 64;
  localparam int STORE_DEPTH   = PLANE_MAX * PLANE_MAX;
  localparam int SETTLE_CYCLES = 16;   // block idle margin after the last result
  localparam int END_CYCLES    = 32;
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_ITEMS   = 34;
  localparam int SHORT_DIM     = 4;    // other plane side when one side is saturated

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_req_type;
  logic [INDEX_W-1:0] in_sample_index;
  logic signed [VALUE_W-1:0] in_sample_value;
  logic [QUERY_W-1:0] in_query_row;
  logic [QUERY_W-1:0] in_query_col;
  logic out_valid;
  logic out_stall;
  logic [LOC_W-1:0] out_max_location;
  logic out_window_empty;

  int fail_total;
  int results_waiting;

  // stimulus shaping state
  bit no_idle;
  bit loaded [0:STORE_DEPTH-1];
  int row_lim, col_lim, plane_area;

  maxpool2d_argmax_location_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_sample_index  (in_sample_index),
    .in_sample_value  (in_sample_value),
    .in_query_row     (in_query_row),
    .in_query_col     (in_query_col),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_max_location (out_max_location),
    .out_window_empty (out_window_empty)
  );

  argmax_checker argmax_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_sample_index  (in_sample_index),
    .in_sample_value  (in_sample_value),
    .in_query_row     (in_query_row),
    .in_query_col     (in_query_col),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_max_location (out_max_location),
    .out_window_empty (out_window_empty),
    .fail_total       (fail_total),
    .results_waiting  (results_waiting)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // hard stop, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("[maxpool2d_argmax_location_unit] ERROR");
    $finish;
  end

  // result side: random stall run before each result beat, none in no-idle stretches
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  // mix of extremes, tie-prone small values and full-range noise
  function automatic int pick_sample();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2, 3:    return int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // zero, the register maximum, or anything in between
  function automatic int pick_extreme(input int maxv);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return maxv;
      default: return int'($urandom_range(0, maxv));
    endcase
  endfunction

  // one request beat: random lead-in gap, then hold until accepted
  task automatic send_beat(input logic kind, input int idx, input int val,
                           input int row, input int col);
    int gap;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_sample_index <= idx[INDEX_W-1:0];
    in_sample_value <= val[VALUE_W-1:0];
    in_query_row    <= row[QUERY_W-1:0];
    in_query_col    <= col[QUERY_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // unused fields carry noise so every bit toggles
  task automatic send_load(input int idx, input int val);
    send_beat(REQ_LOAD, idx, val, $urandom_range(0, 63), $urandom_range(0, 63));
    loaded[idx] = 1'b1;
  endtask

  task automatic send_query(input int row, input int col);
    send_beat(REQ_QUERY, $urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 65535),
              row, col);
  endtask

  // sender holds off until every result beat is back, then lets the block settle
  task automatic wait_until_answered();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
  endtask

  // reprogram the geometry while idle, then load every plane entry a query could read
  task automatic set_geometry(input int ph, input int pw, input int wh, input int ww,
                              input int sr, input int sc, input int pr, input int pc);
    int eff_h, eff_w;
    wait_until_answered();
    write_reg(REG_PLANE_HEIGHT, ph);
    write_reg(REG_PLANE_WIDTH, pw);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_STEP_ROWS, sr);
    write_reg(REG_STEP_COLS, sc);
    write_reg(REG_PAD_ROWS_BEFORE, pr);
    write_reg(REG_PAD_COLS_BEFORE, pc);
    @(negedge clk);
    cfg_we <= 1'b0;
    eff_h = (ph > PLANE_MAX) ? PLANE_MAX : ph;
    eff_w = (pw > PLANE_MAX) ? PLANE_MAX : pw;
    plane_area = eff_h * eff_w;
    // output rows and columns that still touch the plane, plus one past
    row_lim = (eff_h + pr) / ((sr == 0) ? 1 : sr) + 1;
    col_lim = (eff_w + pc) / ((sc == 0) ? 1 : sc) + 1;
    if (row_lim > 63) row_lim = 63;
    if (col_lim > 63) col_lim = 63;
    for (int i = 0; i < plane_area; i++) begin
      if (!loaded[i]) send_load(i, pick_sample());
    end
  endtask

  initial begin
    int idx, row, col;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_req_type     = REQ_LOAD;
    in_sample_index = '0;
    in_sample_value = '0;
    in_query_row    = '0;
    in_query_col    = '0;
    no_idle         = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) loaded[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: 1x1 plane, 2x2 window, stride 2
    send_load(0, -32768);
    send_load(STORE_DEPTH - 1, 32767);
    send_query(0, 0);
    // window lies fully below the plane
    send_query(63, 63);

    // padded 3x3 window on a 4x4 plane, equal maxima at two places
    set_geometry(4, 4, 3, 3, 1, 1, 1, 1);
    send_load(5, 32767);
    send_load(10, 32767);
    send_query(1, 1);
    send_query(0, 0);
    send_query(3, 3);
    send_query(0, 63);

    // zero plane height and zero window width clip everything away
    set_geometry(0, 4, 2, 0, 1, 1, 0, 0);
    send_query(0, 0);
    send_query(1, 2);

    // zero stride, oversized window: every query scans the whole plane
    set_geometry(4, 4, 31, 31, 0, 0, 2, 2);
    send_query(0, 0);
    send_query(63, 63);
    send_query(5, 9);

    // all samples at the most negative value: first scanned must still win
    set_geometry(2, 2, 2, 2, 1, 1, 0, 0);
    for (int i = 0; i < 4; i++) send_load(i, -32768);
    send_query(0, 0);
    send_query(1, 0);

    // random phases: geometry, idle mode, then a mix of loads and queries
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // every other register at its maximum: saturated height and window, short rows
        set_geometry(127, SHORT_DIM, 31, 31, 31, 31, 15, 15);
      end else if (p == 1) begin
        // saturated width on a short plane
        set_geometry(SHORT_DIM, 127, 31, 31, 31, 31, 15, 15);
      end else if ($urandom_range(0, 4) == 0) begin
        // one plane side at an extreme, the other kept short to bound the fill
        if ($urandom_range(0, 1) == 0) begin
          set_geometry(pick_extreme(127), pick_extreme(SHORT_DIM), pick_extreme(31),
                       pick_extreme(31), pick_extreme(31), pick_extreme(31),
                       pick_extreme(15), pick_extreme(15));
        end else begin
          set_geometry(pick_extreme(SHORT_DIM), pick_extreme(127), pick_extreme(31),
                       pick_extreme(31), pick_extreme(31), pick_extreme(31),
                       pick_extreme(15), pick_extreme(15));
        end
      end else begin
        set_geometry($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 5),
                     $urandom_range(1, 5), $urandom_range(0, 4), $urandom_range(0, 4),
                     $urandom_range(0, 3), $urandom_range(0, 3));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // occasional full drain mid-phase
        if ($urandom_range(0, 29) == 0) wait_until_answered();
        if ($urandom_range(0, 99) < 35) begin
          if (plane_area > 0 && $urandom_range(0, 9) != 0) idx = $urandom_range(0, plane_area - 1);
          else idx = $urandom_range(0, STORE_DEPTH - 1);
          send_load(idx, pick_sample());
        end else begin
          row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, row_lim);
          col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, col_lim);
          send_query(row, col);
        end
      end
    end

    // drain and let the block go quiet
    wait_until_answered();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_total == 0 && results_waiting == 0) begin
      $display("[maxpool2d_argmax_location_unit] OK");
    end else begin
      $display("[maxpool2d_argmax_location_unit] ERROR");
    end
    $finish;
  end

endmodule
